FILE: rtl/yta_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and coefficient helpers for the YUV to ARGB converter.
// Depends on nothing; used by every module of the block.
package yta_pkg;

    localparam int MAX_DIMENSION_DEFAULT   = 4096;
    localparam int COEFF_FRAC_BITS_DEFAULT = 14;

    localparam int CFG_DATA_WIDTH  = 13;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic FMT_NV21   = 1'b0;
    localparam logic FMT_YUV420 = 1'b1;

    localparam logic [CFG_DATA_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DATA_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam int MILLI_RV = 1402;
    localparam int MILLI_GU = 344;
    localparam int MILLI_GV = 714;
    localparam int MILLI_BU = 1772;

    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
    localparam logic [7:0] BYTE_MAX      = 8'd255;

    localparam int INDEX_WIDTH = 24;

    // Coefficient in fixed point, rounded with ties going up.
    function automatic longint coef_q(input longint milli, input int frac_bits);
        return ((milli << frac_bits) + 64'sd500) / 1000;
    endfunction

endpackage

FILE: rtl/yuv_to_argb_flip_converter.sv
`timescale 1ns / 1ps
// Top level of the YUV to ARGB converter with vertically flipped destination index.
// Depends on yta_pkg, yta_raster_counter and yta_color_matrix.
//
// Pixels enter on the s_ stream in raster order, one beat per pixel, and leave
// on the m_ stream as one beat each: the packed ARGB word, the flipped
// destination index and tlast on the final pixel of the frame.
// The configuration port takes pixel format, frame width and frame height;
// write it only while no beat is in flight.
// Throughput is one pixel per clock cycle while m_tready stays high. A beat
// accepted is registered at the input, converted by the colour matrix and the
// index multiplier, and captured in the result register once that register is
// free; it is then offered on m_tvalid.
// When the receiver holds m_tready low the result register keeps its beat and
// the input register can still take one more beat before s_tready falls.
// Reset empties both registers, clears the raster counters and restores the
// configuration to NV21, 640 by 480. Changing the frame size does not clear
// the counters; a counter beyond the new size restarts at zero.
module yuv_to_argb_flip_converter #(
    parameter int MAX_DIMENSION   = yta_pkg::MAX_DIMENSION_DEFAULT,
    parameter int COEFF_FRAC_BITS = yta_pkg::COEFF_FRAC_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [yta_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [yta_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // luma [7:0], chroma_first [15:8], chroma_second [23:16]
    input  logic [23:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // argb_pixel [31:0], dest_index [55:32]
    output logic [55:0]                         m_tdata,
    output logic                                m_tlast
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int IW = yta_pkg::INDEX_WIDTH;
    localparam int XW = (2 * DW + 1 > IW) ? 2 * DW + 1 : IW;

    logic                               pixel_format_reg;
    logic [yta_pkg::CFG_DATA_WIDTH-1:0] frame_width_reg;
    logic [yta_pkg::CFG_DATA_WIDTH-1:0] frame_height_reg;

    logic          in_valid_reg;
    logic [23:0]   in_data_reg;
    logic [CW-1:0] in_column_reg;
    logic [CW-1:0] in_row_reg;
    logic          in_last_reg;

    logic          out_valid_reg;
    logic [31:0]   out_argb_reg;
    logic [IW-1:0] out_index_reg;
    logic          out_last_reg;

    logic          accept;
    logic          out_free;
    logic          move;
    logic [DW-1:0] width_eff;
    logic [DW-1:0] height_eff;
    logic [CW-1:0] column_pos;
    logic [CW-1:0] row_pos;
    logic          frame_end;
    logic [31:0]   argb_pixel;
    logic [DW-1:0] flipped_row;
    logic [XW-1:0] index_full;

    assign out_free = !out_valid_reg || m_tready;
    assign move     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= yta_pkg::FMT_NV21;
            frame_width_reg  <= yta_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= yta_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                yta_pkg::REG_PIXEL_FORMAT: begin
                    pixel_format_reg <= cfg_wdata[0];
                end
                yta_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata;
                end
                yta_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    yta_raster_counter #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_raster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .column_pos   (column_pos),
        .row_pos      (row_pos),
        .frame_end    (frame_end)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (move) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg   <= s_tdata;
            in_column_reg <= column_pos;
            in_row_reg    <= row_pos;
            in_last_reg   <= frame_end;
        end
    end

    yta_color_matrix #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_matrix (
        .pixel_format  (pixel_format_reg),
        .luma          (in_data_reg[7:0]),
        .chroma_first  (in_data_reg[15:8]),
        .chroma_second (in_data_reg[23:16]),
        .argb_pixel    (argb_pixel)
    );

    assign flipped_row = height_eff - DW'(1) - DW'(in_row_reg);
    assign index_full  = XW'(flipped_row) * XW'(width_eff) + XW'(in_column_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_argb_reg  <= argb_pixel;
            out_index_reg <= index_full[IW-1:0];
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_argb_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/yta_color_matrix.sv
`timescale 1ns / 1ps
// Full-range BT.601 YUV to opaque ARGB conversion for one pixel, purely combinational.
// Depends on yta_pkg for the chroma order codes and coefficients.
module yta_color_matrix #(
    parameter int COEFF_FRAC_BITS = yta_pkg::COEFF_FRAC_BITS_DEFAULT
) (
    input  logic        pixel_format,
    input  logic [7:0]  luma,
    input  logic [7:0]  chroma_first,
    input  logic [7:0]  chroma_second,
    output logic [31:0] argb_pixel
);

    localparam int SW = COEFF_FRAC_BITS + 11;

    localparam logic signed [SW-1:0] K_RV =
        SW'(yta_pkg::coef_q(yta_pkg::MILLI_RV, COEFF_FRAC_BITS));
    localparam logic signed [SW-1:0] K_GU =
        SW'(yta_pkg::coef_q(yta_pkg::MILLI_GU, COEFF_FRAC_BITS));
    localparam logic signed [SW-1:0] K_GV =
        SW'(yta_pkg::coef_q(yta_pkg::MILLI_GV, COEFF_FRAC_BITS));
    localparam logic signed [SW-1:0] K_BU =
        SW'(yta_pkg::coef_q(yta_pkg::MILLI_BU, COEFF_FRAC_BITS));

    logic signed [8:0]    c1;
    logic signed [8:0]    c2;
    logic signed [8:0]    u;
    logic signed [8:0]    v;
    logic signed [SW-1:0] u_ext;
    logic signed [SW-1:0] v_ext;
    logic signed [SW-1:0] ys;
    logic signed [SW-1:0] sum_r;
    logic signed [SW-1:0] sum_g;
    logic signed [SW-1:0] sum_b;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;

    function automatic logic [7:0] to_byte(input logic signed [SW-1:0] sum);
        logic [SW-COEFF_FRAC_BITS-1:0] whole;
        whole = sum[SW-1:COEFF_FRAC_BITS];
        if (sum[SW-1]) begin
            return 8'd0;
        end else if (|whole[SW-COEFF_FRAC_BITS-1:8]) begin
            return yta_pkg::BYTE_MAX;
        end else begin
            return whole[7:0];
        end
    endfunction

    assign c1 = $signed({1'b0, chroma_first}) - $signed({1'b0, yta_pkg::CHROMA_OFFSET});
    assign c2 = $signed({1'b0, chroma_second}) - $signed({1'b0, yta_pkg::CHROMA_OFFSET});

    always_comb begin
        if (pixel_format == yta_pkg::FMT_YUV420) begin
            u = c1;
            v = c2;
        end else begin
            v = c1;
            u = c2;
        end
    end

    assign u_ext = {{(SW-9){u[8]}}, u};
    assign v_ext = {{(SW-9){v[8]}}, v};
    assign ys    = $signed({3'b000, luma, {COEFF_FRAC_BITS{1'b0}}});

    assign sum_r = ys + K_RV * v_ext;
    assign sum_g = ys - K_GU * u_ext - K_GV * v_ext;
    assign sum_b = ys + K_BU * u_ext;

    assign red   = to_byte(sum_r);
    assign green = to_byte(sum_g);
    assign blue  = to_byte(sum_b);

    assign argb_pixel = {yta_pkg::ALPHA_OPAQUE, red, green, blue};

endmodule

FILE: rtl/yta_raster_counter.sv
`timescale 1ns / 1ps
// Column and row counters of the raster scan, with frame size clamping and wrap.
// Depends on yta_pkg for the configuration data width.
module yta_raster_counter #(
    parameter int MAX_DIMENSION = yta_pkg::MAX_DIMENSION_DEFAULT,
    localparam int DW = $clog2(MAX_DIMENSION + 1),
    localparam int CW = $clog2(MAX_DIMENSION)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic [yta_pkg::CFG_DATA_WIDTH-1:0]  frame_width,
    input  logic [yta_pkg::CFG_DATA_WIDTH-1:0]  frame_height,
    output logic [DW-1:0]                       width_eff,
    output logic [DW-1:0]                       height_eff,
    output logic [CW-1:0]                       column_pos,
    output logic [CW-1:0]                       row_pos,
    output logic                                frame_end
);

    localparam int EW = (DW > yta_pkg::CFG_DATA_WIDTH) ? DW : yta_pkg::CFG_DATA_WIDTH;

    logic [CW-1:0] column_count_reg;
    logic [CW-1:0] column_count_next;
    logic [CW-1:0] row_count_reg;
    logic [CW-1:0] row_count_next;
    logic [DW-1:0] column_inc;
    logic [DW-1:0] row_inc;

    function automatic logic [DW-1:0] eff_size(input logic [yta_pkg::CFG_DATA_WIDTH-1:0] v);
        logic [EW-1:0] v_ext;
        v_ext = EW'(v);
        if (v_ext == '0) begin
            return DW'(1);
        end else if (v_ext > EW'(MAX_DIMENSION)) begin
            return DW'(MAX_DIMENSION);
        end else begin
            return v_ext[DW-1:0];
        end
    endfunction

    assign width_eff  = eff_size(frame_width);
    assign height_eff = eff_size(frame_height);

    assign column_pos = (DW'(column_count_reg) >= width_eff)  ? '0 : column_count_reg;
    assign row_pos    = (DW'(row_count_reg)    >= height_eff) ? '0 : row_count_reg;

    assign column_inc = DW'(column_pos) + DW'(1);
    assign row_inc    = DW'(row_pos) + DW'(1);

    assign frame_end = (DW'(row_pos) == height_eff - DW'(1)) &&
                       (DW'(column_pos) == width_eff - DW'(1));

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance) begin
            if (column_inc >= width_eff) begin
                column_count_next = '0;
                row_count_next    = (row_inc >= height_eff) ? '0 : row_inc[CW-1:0];
            end else begin
                column_count_next = column_inc[CW-1:0];
                row_count_next    = row_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

FILE: tb/yuv_to_argb_flip_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for yuv_to_argb_flip_converter: pixel beats go in on the s_ stream and
// every m_ beat is checked against a scoreboard that predicts colour, flipped index and tlast.
// Depends on yta_pkg and the converter RTL.

typedef struct packed {
    logic [31:0] argb_pixel;
    logic [23:0] dest_index;
    logic        frame_end;
} flipped_pixel_t;

class flip_pixel_scoreboard;
    localparam int     Q_FRAC  = yta_pkg::COEFF_FRAC_BITS_DEFAULT;
    localparam int     MAX_DIM = yta_pkg::MAX_DIMENSION_DEFAULT;
    localparam longint K_RV    = (1402 * (1 << Q_FRAC) + 500) / 1000;
    localparam longint K_GU    = (344 * (1 << Q_FRAC) + 500) / 1000;
    localparam longint K_GV    = (714 * (1 << Q_FRAC) + 500) / 1000;
    localparam longint K_BU    = (1772 * (1 << Q_FRAC) + 500) / 1000;

    logic           format_reg;
    logic [12:0]    width_reg;
    logic [12:0]    height_reg;
    int             column;
    int             row;
    flipped_pixel_t expected_pixels[$];
    int             mismatches;

    function new();
        format_reg = yta_pkg::FMT_NV21;
        width_reg  = yta_pkg::FRAME_WIDTH_RESET;
        height_reg = yta_pkg::FRAME_HEIGHT_RESET;
        column     = 0;
        row        = 0;
        mismatches = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [12:0] value);
        unique case (idx)
            yta_pkg::REG_PIXEL_FORMAT: format_reg = value[0];
            yta_pkg::REG_FRAME_WIDTH:  width_reg  = value;
            yta_pkg::REG_FRAME_HEIGHT: height_reg = value;
            default: ;
        endcase
    endfunction

    function int active_dimension(logic [12:0] value);
        if (value == 0) return 1;
        if (value > MAX_DIM) return MAX_DIM;
        return value;
    endfunction

    function logic [7:0] to_channel(longint acc);
        longint t;
        if (acc < 0) return 8'd0;
        t = acc >>> Q_FRAC;
        if (t > 255) return 8'd255;
        return t[7:0];
    endfunction

    function void note_pixel(logic [7:0] luma, logic [7:0] chroma_first,
                             logic [7:0] chroma_second);
        int             w;
        int             h;
        int             index_full;
        longint         first_c;
        longint         second_c;
        longint         u;
        longint         v;
        longint         ys;
        flipped_pixel_t e;
        w        = active_dimension(width_reg);
        h        = active_dimension(height_reg);
        first_c  = longint'(chroma_first) - longint'(yta_pkg::CHROMA_OFFSET);
        second_c = longint'(chroma_second) - longint'(yta_pkg::CHROMA_OFFSET);
        if (format_reg == yta_pkg::FMT_YUV420) begin
            u = first_c;
            v = second_c;
        end else begin
            v = first_c;
            u = second_c;
        end
        ys = longint'(luma) << Q_FRAC;
        e.argb_pixel = {yta_pkg::ALPHA_OPAQUE, to_channel(ys + K_RV * v),
                        to_channel(ys - K_GU * u - K_GV * v), to_channel(ys + K_BU * u)};
        if (column >= w) column = 0;
        if (row >= h) row = 0;
        index_full   = (h - 1 - row) * w + column;
        e.dest_index = index_full[23:0];
        e.frame_end  = (row == h - 1) && (column == w - 1);
        expected_pixels.push_back(e);
        if (column + 1 >= w) begin
            column = 0;
            row    = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            column++;
        end
    endfunction

    function void check_pixel(logic [31:0] argb_pixel, logic [23:0] dest_index,
                              logic frame_end);
        flipped_pixel_t e;
        if (expected_pixels.size() == 0) begin
            $error("unexpected result beat: argb_pixel %h, dest_index %0d", argb_pixel,
                   dest_index);
            mismatches++;
            return;
        end
        e = expected_pixels.pop_front();
        if (argb_pixel !== e.argb_pixel) begin
            $error("argb_pixel: expected %h, actual %h", e.argb_pixel, argb_pixel);
            mismatches++;
        end
        if (dest_index !== e.dest_index) begin
            $error("dest_index: expected %0d, actual %0d", e.dest_index, dest_index);
            mismatches++;
        end
        if (frame_end !== e.frame_end) begin
            $error("frame_end: expected %b, actual %b", e.frame_end, frame_end);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction
endclass

module yuv_to_argb_flip_converter_tb;

    localparam logic [yta_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int LONG_HOLD      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 700;
    localparam int QUIET_TAIL     = 100;

    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [yta_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr  = '0;
    logic [yta_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [23:0]                         s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [55:0]                         m_tdata;
    logic                                m_tlast;

    logic quiet         = 1'b0;
    logic long_hold_req = 1'b0;
    int   stalled_cycles = 0;

    flip_pixel_scoreboard sb = new();

    yuv_to_argb_flip_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] chroma_first,
                              input logic [7:0] chroma_second);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {chroma_second, chroma_first, luma};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(luma, chroma_first, chroma_second);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
    endtask

    task automatic drain_pixels();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [yta_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [yta_pkg::CFG_DATA_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_register(idx, value);
    endtask

    function automatic logic [yta_pkg::CFG_DATA_WIDTH-1:0] pick_dimension();
        unique case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        int sent;
        int count;
        int phase;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Colour extremes at the reset format and size, clamping each channel both ways.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd16, 8'd240, 8'd16);
        send_pixel(8'd235, 8'd16, 8'd240);
        send_pixel(8'd255, 8'd128, 8'd128);
        drain_pixels();

        // The column counter now lies beyond the new width and must restart.
        write_reg(yta_pkg::REG_PIXEL_FORMAT, 13'(yta_pkg::FMT_YUV420));
        write_reg(yta_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(yta_pkg::REG_FRAME_HEIGHT, 13'd2);
        send_random_pixels(7);
        drain_pixels();

        write_reg(yta_pkg::REG_PIXEL_FORMAT, 13'(yta_pkg::FMT_NV21));
        write_reg(yta_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(yta_pkg::REG_FRAME_HEIGHT, 13'd0);
        send_random_pixels(3);
        drain_pixels();

        write_reg(yta_pkg::REG_FRAME_WIDTH, 13'd8191);
        write_reg(yta_pkg::REG_FRAME_HEIGHT, 13'd4097);
        send_random_pixels(2);
        drain_pixels();

        write_reg(REG_UNUSED, 13'h1FFF);
        write_reg(yta_pkg::REG_FRAME_WIDTH, 13'd4096);
        write_reg(yta_pkg::REG_FRAME_HEIGHT, 13'd1);
        send_random_pixels(3);
        drain_pixels();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            count = $urandom_range(20, 60);
            write_reg(yta_pkg::REG_PIXEL_FORMAT, 13'($urandom_range(0, 8191)));
            write_reg(yta_pkg::REG_FRAME_WIDTH, pick_dimension());
            write_reg(yta_pkg::REG_FRAME_HEIGHT, pick_dimension());
            if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
            quiet = (sent >= RANDOM_PIXELS - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                quiet         = 1'b0;
                long_hold_req = 1'b1;
            end
            send_random_pixels(count);
            drain_pixels();
            sent += count;
            phase++;
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : ready_driver
        int hold_left;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel(m_tdata[31:0], m_tdata[55:32], m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
